/* rtl/mwfq_pkg.sv */
// Package with the shared types, frame constants and CRC step for the Modbus frame queue.
`default_nettype none

package mwfq_pkg;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_EMIT
    } mwfq_state_t;

    // Input operation codes.
    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Frame layout.
    localparam logic [7:0] SLAVE_ID         = 8'h00;
    localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;
    localparam logic [7:0] COUNT_HIGH       = 8'h00;
    localparam int         HEADER_LEN       = 7;
    localparam int         FRAME_OVERHEAD   = 9;

    // Header byte positions.
    localparam int POS_SLAVE     = 0;
    localparam int POS_FUNC      = 1;
    localparam int POS_ADDR_HI   = 2;
    localparam int POS_ADDR_LO   = 3;
    localparam int POS_COUNT_HI  = 4;
    localparam int POS_COUNT_LO  = 5;
    localparam int POS_BYTE_CNT  = 6;

    // CRC-16/MODBUS.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Folds one byte into the running CRC, one bit per step.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/modbus_write_frame_queue_top.sv */
// Modbus RTU write-multiple-registers frame builder with a ring of queued frames.
// Text bytes are taken while idle; the closing byte starts a build, unless the ring is full,
// that writes one frame byte per cycle through the frame memory write port, during which no item is taken.
// A tick with a queued frame holds off input until all its bytes are read, which output stalls delay;
// each byte passes the frame memory read register, then the output register, one byte per cycle while
// the output is taken, a rate set by the frame memory read port.
// Reset clears the slot pointers, text count, held address and handshake state, not the memories.
`default_nettype none

module modbus_write_frame_queue_top #(
    parameter int QUEUE_DEPTH = 8,
    parameter int MAX_TEXT    = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [7:0]  text_byte,
    input  wire logic        text_last,
    input  wire logic [15:0] widget_address,
    input  wire logic [5:0]  text_limit,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       tx_byte,
    output logic             frame_end
);
    import mwfq_pkg::*;

    localparam int FRAME_MAX = FRAME_OVERHEAD + ((MAX_TEXT + 1) / 2) * 2;
    localparam int LEN_W     = $clog2(FRAME_MAX + 1);
    localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
    localparam int TC_W      = $clog2(MAX_TEXT + 1);
    localparam int TA_W      = $clog2(MAX_TEXT);
    localparam int FS_DEPTH  = QUEUE_DEPTH * FRAME_MAX;
    localparam int FS_AW     = $clog2(FS_DEPTH);

    // Memories.
    logic [7:0]       text_mem  [MAX_TEXT];
    logic [7:0]       frame_mem [FS_DEPTH];
    logic [LEN_W-1:0] len_mem   [QUEUE_DEPTH];

    // Control and datapath registers.
    mwfq_state_t       state_reg, state_next;
    logic [TC_W-1:0]   text_count_reg, text_count_next;
    logic [15:0]       held_addr_reg, held_addr_next;
    logic [TC_W-1:0]   n_reg, n_next;
    logic [LEN_W-1:0]  bytes_reg, bytes_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic              wr_vld_reg, wr_vld_next;
    logic [LEN_W-1:0]  wr_pos_reg, wr_pos_next;
    logic              txt_ok_reg, txt_ok_next;
    logic [15:0]       crc_reg, crc_next;
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic [LEN_W-1:0]  em_pos_reg, em_pos_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              rd_last_reg, rd_last_next;
    logic              out_vld_reg, out_vld_next;
    logic [7:0]        tx_byte_reg, tx_byte_next;
    logic              frame_end_reg, frame_end_next;
    logic [7:0]        text_rdata_reg;
    logic [7:0]        fs_rdata_reg;
    logic [LEN_W-1:0]  len_rdata_reg;

    // Memory port controls.
    logic              tb_we, tb_re;
    logic [TA_W-1:0]   tb_waddr, tb_raddr;
    logic              fs_we, fs_re;
    logic [FS_AW-1:0]  fs_waddr, fs_raddr;
    logic [7:0]        fs_wdata;
    logic              len_we;
    logic              len_re;

    // Helper values.
    logic [TC_W-1:0]   lim;
    logic [TC_W-1:0]   count_inc;
    logic [TC_W:0]     n_plus;
    logic [SLOT_W-1:0] write_slot_inc;
    logic [SLOT_W-1:0] read_slot_inc;
    logic              queue_full;
    logic              queue_empty;
    logic [LEN_W-1:0]  text_end;
    logic [LEN_W-1:0]  last_pos;
    logic [LEN_W-1:0]  j_idx;
    logic [LEN_W-1:0]  t_idx;
    logic [7:0]        build_byte;
    logic              move;
    logic              room;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_vld_reg;
    assign tx_byte   = tx_byte_reg;
    assign frame_end = frame_end_reg;

    // Ring pointer arithmetic.
    assign write_slot_inc = (write_slot_reg == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : write_slot_reg + 1'b1;
    assign read_slot_inc  = (read_slot_reg == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : read_slot_reg + 1'b1;
    assign queue_full  = (write_slot_inc == read_slot_reg);
    assign queue_empty = (write_slot_reg == read_slot_reg);

    // Text limit capped to the buffer size.
    assign lim = (text_limit > 6'(MAX_TEXT)) ? TC_W'(MAX_TEXT) : TC_W'(text_limit);

    // Frame positions of the end of text and of the CRC high byte.
    assign text_end = LEN_W'(HEADER_LEN) + bytes_reg;
    assign last_pos = text_end + 1'b1;

    // Text index for the byte issued this cycle: pairs are swapped.
    assign j_idx = pos_reg - LEN_W'(HEADER_LEN);
    assign t_idx = j_idx ^ LEN_W'(1);

    // Output stage: the read data register acts as a skid buffer.
    assign move = rd_valid_reg && (!out_vld_reg || out_ready);
    assign room = !rd_valid_reg || move;

    // Byte produced by the write stage of the build.
    always_comb begin
        build_byte = txt_ok_reg ? text_rdata_reg : 8'h00;
        if (wr_pos_reg == LEN_W'(POS_SLAVE)) begin
            build_byte = SLAVE_ID;
        end
        else if (wr_pos_reg == LEN_W'(POS_FUNC)) begin
            build_byte = FUNC_WRITE_MULTI;
        end
        else if (wr_pos_reg == LEN_W'(POS_ADDR_HI)) begin
            build_byte = held_addr_reg[15:8];
        end
        else if (wr_pos_reg == LEN_W'(POS_ADDR_LO)) begin
            build_byte = held_addr_reg[7:0];
        end
        else if (wr_pos_reg == LEN_W'(POS_COUNT_HI)) begin
            build_byte = COUNT_HIGH;
        end
        else if (wr_pos_reg == LEN_W'(POS_COUNT_LO)) begin
            build_byte = 8'(bytes_reg >> 1);
        end
        else if (wr_pos_reg == LEN_W'(POS_BYTE_CNT)) begin
            build_byte = 8'(bytes_reg);
        end
        else if (wr_pos_reg == text_end) begin
            build_byte = crc_reg[7:0];
        end
        else if (wr_pos_reg == last_pos) begin
            build_byte = crc_reg[15:8];
        end
    end

    // Next state, memory port controls and datapath updates.
    always_comb begin
        state_next      = state_reg;
        text_count_next = text_count_reg;
        held_addr_next  = held_addr_reg;
        n_next          = n_reg;
        bytes_next      = bytes_reg;
        pos_next        = pos_reg;
        wr_vld_next     = 1'b0;
        wr_pos_next     = pos_reg;
        txt_ok_next     = 1'b0;
        crc_next        = crc_reg;
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        em_pos_next     = em_pos_reg;
        rd_last_next    = rd_last_reg;
        count_inc       = text_count_reg;
        n_plus          = '0;
        tb_we           = 1'b0;
        tb_waddr        = text_count_reg[TA_W-1:0];
        tb_re           = 1'b0;
        tb_raddr        = t_idx[TA_W-1:0];
        fs_we           = 1'b0;
        fs_waddr        = FS_AW'(write_slot_reg) * FS_AW'(FRAME_MAX) + FS_AW'(wr_pos_reg);
        fs_wdata        = build_byte;
        fs_re           = 1'b0;
        fs_raddr        = FS_AW'(read_slot_reg) * FS_AW'(FRAME_MAX) + FS_AW'(em_pos_reg);
        len_we          = 1'b0;
        len_re          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    if (op == OP_TEXT) begin
                        // Collect one text byte and close the frame on the last one.
                        if (text_count_reg == '0) begin
                            held_addr_next = widget_address;
                        end
                        if (text_count_reg < lim) begin
                            tb_we     = 1'b1;
                            count_inc = text_count_reg + 1'b1;
                        end
                        text_count_next = count_inc;
                        if (text_last) begin
                            text_count_next = '0;
                            if (!queue_full) begin
                                n_plus     = {1'b0, count_inc} + 1'b1;
                                n_next     = count_inc;
                                bytes_next = LEN_W'({n_plus[TC_W:1], 1'b0});
                                pos_next   = '0;
                                crc_next   = CRC_INIT;
                                state_next = ST_BUILD;
                            end
                        end
                    end
                    else if (!queue_empty) begin
                        // Start emitting the oldest queued frame; its length is read now.
                        em_pos_next = '0;
                        len_re      = 1'b1;
                        state_next  = ST_EMIT;
                    end
                end
            end

            ST_BUILD:
            begin
                // Issue stage: read the text byte for this frame position.
                if (pos_reg <= last_pos) begin
                    wr_vld_next = 1'b1;
                    pos_next    = pos_reg + 1'b1;
                    if ((pos_reg >= LEN_W'(HEADER_LEN)) && (pos_reg < text_end)
                        && (t_idx < LEN_W'(n_reg))) begin
                        txt_ok_next = 1'b1;
                        tb_re       = 1'b1;
                    end
                end
                // Write stage: store the byte and fold it into the CRC.
                if (wr_vld_reg) begin
                    fs_we = 1'b1;
                    if (wr_pos_reg < text_end) begin
                        crc_next = crc16_byte(crc_reg, build_byte);
                    end
                    if (wr_pos_reg == last_pos) begin
                        len_we          = 1'b1;
                        write_slot_next = write_slot_inc;
                        state_next      = ST_IDLE;
                    end
                end
            end

            ST_EMIT:
            begin
                // Read one frame byte whenever the skid register has room.
                if (em_pos_reg == len_rdata_reg) begin
                    read_slot_next = read_slot_inc;
                    state_next     = ST_IDLE;
                end
                else if (room) begin
                    fs_re        = 1'b1;
                    rd_last_next = (em_pos_reg == len_rdata_reg - 1'b1);
                    em_pos_next  = em_pos_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register and skid tracking.
    always_comb begin
        rd_valid_next  = fs_re ? 1'b1 : (move ? 1'b0 : rd_valid_reg);
        out_vld_next   = move ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);
        tx_byte_next   = move ? fs_rdata_reg : tx_byte_reg;
        frame_end_next = move ? rd_last_reg : frame_end_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            text_count_reg <= '0;
            held_addr_reg  <= '0;
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            wr_vld_reg     <= 1'b0;
            rd_valid_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else begin
            state_reg      <= state_next;
            text_count_reg <= text_count_next;
            held_addr_reg  <= held_addr_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            wr_vld_reg     <= wr_vld_next;
            rd_valid_reg   <= rd_valid_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk) begin
        n_reg         <= n_next;
        bytes_reg     <= bytes_next;
        pos_reg       <= pos_next;
        wr_pos_reg    <= wr_pos_next;
        txt_ok_reg    <= txt_ok_next;
        crc_reg       <= crc_next;
        em_pos_reg    <= em_pos_next;
        rd_last_reg   <= rd_last_next;
        tx_byte_reg   <= tx_byte_next;
        frame_end_reg <= frame_end_next;
    end

    // Text buffer memory.
    always_ff @(posedge clk) begin
        if (tb_we) begin
            text_mem[tb_waddr] <= text_byte;
        end
        if (tb_re) begin
            text_rdata_reg <= text_mem[tb_raddr];
        end
    end

    // Frame store memory.
    always_ff @(posedge clk) begin
        if (fs_we) begin
            frame_mem[fs_waddr] <= fs_wdata;
        end
        if (fs_re) begin
            fs_rdata_reg <= frame_mem[fs_raddr];
        end
    end

    // Frame length table, one entry per slot, read when a tick is accepted.
    always_ff @(posedge clk) begin
        if (len_we) begin
            len_mem[write_slot_reg] <= last_pos + 1'b1;
        end
        if (len_re) begin
            len_rdata_reg <= len_mem[read_slot_reg];
        end
    end

    // A frame is only built into a slot that leaves the ring short of full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUILD) |-> !queue_full)
        else $error("frame build started with a full queue");

    // Emitting needs a queued frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !queue_empty)
        else $error("frame emit with an empty queue");

    // A frame memory read never overwrites an unconsumed byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        fs_re |-> (!rd_valid_reg || move))
        else $error("frame byte overwritten in skid register");

    // Finishing a build advances the write slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUILD && wr_vld_reg && wr_pos_reg == last_pos)
        |=> (write_slot_reg != $past(write_slot_reg)))
        else $error("write slot did not advance after build");

    // Frame memory is never read and written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(fs_we && fs_re))
        else $error("frame memory read and write overlap");

endmodule

`default_nettype wire

/* tb/modbus_write_frame_queue_top_tb.sv */
// Self-checking testbench for the Modbus write-multiple-registers frame queue.
`timescale 1ns / 100ps

module modbus_write_frame_queue_top_tb;

    import mwfq_pkg::*;

    localparam int QDEPTH      = 8;
    localparam int MAXTXT      = 32;
    localparam int FRAME_BYTES = 9 + ((MAXTXT + 1) / 2) * 2;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 80;

    // One transmitted frame byte as seen on the output channel.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } tx_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [7:0]  text_byte;
    logic        text_last;
    logic [15:0] widget_address;
    logic [5:0]  text_limit;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  tx_byte;
    logic        frame_end;

    // Predicted frame bytes still to come out of the block, oldest first.
    tx_beat_t    expected_bytes[$];

    // Local copy of the frame ring and of the text under construction.
    logic [7:0]  ring_bytes [QDEPTH][FRAME_BYTES];
    int          ring_len [QDEPTH];
    int          rd_slot;
    int          wr_slot;
    int          txt_count;
    logic [15:0] latched_addr;
    logic [7:0]  txt_buf [MAXTXT];

    int          error_count;
    int          cycle_count;
    int          stall_left;
    bit          in_idle_on;
    bit          out_idle_on;

    modbus_write_frame_queue_top #(
        .QUEUE_DEPTH (QDEPTH),
        .MAX_TEXT    (MAXTXT)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .text_byte      (text_byte),
        .text_last      (text_last),
        .widget_address (widget_address),
        .text_limit     (text_limit),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tx_byte        (tx_byte),
        .frame_end      (frame_end)
    );

    // Free-running clock.
    always #5 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // One CRC-16/MODBUS byte step, LSB first with the reflected polynomial.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ 16'hA001;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Closes the text: builds the frame into the next ring slot unless the ring is full.
    function automatic void close_text_frame();
        int          n;
        int          regs;
        int          nbytes;
        int          next;
        logic [15:0] crc;
        n      = txt_count;
        regs   = (n + 1) / 2;
        nbytes = regs * 2;
        next   = (wr_slot + 1) % QDEPTH;
        txt_count = 0;
        if (next == rd_slot)
            return;
        ring_bytes[wr_slot][0] = 8'h00;
        ring_bytes[wr_slot][1] = 8'h10;
        ring_bytes[wr_slot][2] = latched_addr[15:8];
        ring_bytes[wr_slot][3] = latched_addr[7:0];
        ring_bytes[wr_slot][4] = 8'h00;
        ring_bytes[wr_slot][5] = 8'(regs);
        ring_bytes[wr_slot][6] = 8'(nbytes);
        // Byte pairs go out swapped; an odd last byte is padded with zero.
        for (int i = 0; i < nbytes; i += 2)
        begin
            ring_bytes[wr_slot][7 + i] = (i + 1 < n) ? txt_buf[i + 1] : 8'h00;
            ring_bytes[wr_slot][8 + i] = txt_buf[i];
        end
        crc = 16'hFFFF;
        for (int k = 0; k < 7 + nbytes; k++)
            crc = crc_fold(crc, ring_bytes[wr_slot][k]);
        ring_bytes[wr_slot][7 + nbytes] = crc[7:0];
        ring_bytes[wr_slot][8 + nbytes] = crc[15:8];
        ring_len[wr_slot] = 9 + nbytes;
        wr_slot = next;
    endfunction

    // Updates the local state for one accepted transaction and queues any frame bytes it emits.
    function automatic void predict_frame_bytes(input logic o, input logic [7:0] b,
                                                input logic l, input logic [15:0] a,
                                                input logic [5:0] lim);
        int       cap;
        tx_beat_t beat;
        if (o == OP_TEXT)
        begin
            cap = (lim > MAXTXT) ? MAXTXT : int'(lim);
            if (txt_count == 0)
                latched_addr = a;
            if (txt_count < cap)
            begin
                txt_buf[txt_count] = b;
                txt_count++;
            end
            if (l)
                close_text_frame();
        end
        else if (rd_slot != wr_slot)
        begin
            for (int k = 0; k < ring_len[rd_slot]; k++)
            begin
                beat.data = ring_bytes[rd_slot][k];
                beat.last = (k == ring_len[rd_slot] - 1);
                expected_bytes.push_back(beat);
            end
            rd_slot = (rd_slot + 1) % QDEPTH;
        end
    endfunction

    // Sends one input transaction after a random gap and waits for it to be taken.
    task automatic send_item(input logic o, input logic [7:0] b, input logic l,
                             input logic [15:0] a, input logic [5:0] lim);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        op             <= o;
        text_byte      <= b;
        text_last      <= l;
        widget_address <= a;
        text_limit     <= lim;
        do
            @(posedge clk);
        while (!in_ready);
        predict_frame_bytes(o, b, l, a, lim);
    endtask

    // Output side: random back-pressure and comparison of every transaction.
    always @(posedge clk)
    begin
        tx_beat_t want;
        int       wait_cycles;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected byte %02h end %0b", tx_byte, frame_end));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (tx_byte !== want.data)
                        report_mismatch($sformatf("tx_byte %02h, expected %02h",
                                                  tx_byte, want.data));
                    if (frame_end !== want.last)
                        report_mismatch($sformatf("frame_end %0b, expected %0b on byte %02h",
                                                  frame_end, want.last, want.data));
                end
            end
            // A fresh stall is drawn once per result; a countdown releases it.
            if (out_ready)
            begin
                if (out_valid)
                begin
                    wait_cycles = out_idle_on ? $urandom_range(0, 12) : 0;
                    if (wait_cycles > 0)
                    begin
                        out_ready  <= 1'b0;
                        stall_left <= wait_cycles;
                    end
                end
            end
            else if (stall_left <= 1)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                stall_left <= stall_left - 1;
            end
        end
    end

    // A tick with nothing queued must produce no output.
    task automatic test_tick_on_empty_queue();
        send_item(OP_TICK, 8'hFF, 1'b1, 16'hFFFF, 6'h3F);
    endtask

    // Extreme byte and address values, a limit above the cap and an odd text length.
    task automatic test_field_extremes();
        send_item(OP_TEXT, 8'hFF, 1'b0, 16'hFFFF, 6'h3F);
        send_item(OP_TEXT, 8'h00, 1'b0, 16'h0000, 6'h3F);
        send_item(OP_TEXT, 8'hA5, 1'b1, 16'h0000, 6'h3F);
        send_item(OP_TICK, 8'h00, 1'b0, 16'h0000, 6'h00);
    endtask

    // The closing byte arrives past the limit and is dropped, yet still closes the frame.
    task automatic test_text_past_limit();
        send_item(OP_TEXT, 8'h3C, 1'b0, 16'h5AA5, 6'd1);
        send_item(OP_TEXT, 8'hC3, 1'b1, 16'h1111, 6'd1);
        send_item(OP_TICK, 8'h55, 1'b1, 16'h2222, 6'd1);
    endtask

    // Empty frames fill the ring until one is dropped, then the ring is drained.
    task automatic test_queue_full();
        // With a limit of zero the address is retaken on every byte.
        send_item(OP_TEXT, 8'h11, 1'b0, 16'h1234, 6'd0);
        send_item(OP_TEXT, 8'h22, 1'b1, 16'hBEEF, 6'd0);
        for (int i = 1; i < QDEPTH; i++)
            send_item(OP_TEXT, 8'(i), 1'b1, 16'(i * 16'h0101), 6'd0);
        for (int i = 0; i < QDEPTH; i++)
            send_item(OP_TICK, 8'(i), 1'b0, 16'h0000, 6'd0);
    endtask

    // Mostly well-formed frames with random content, mixed with ticks and stray items.
    task automatic test_random_traffic();
        int sent;
        int n;
        int lim;
        int pick;
        sent = 0;
        while (sent < 230)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                in_idle_on  = ($urandom_range(0, 3) != 0);
                out_idle_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // Most frames are short; a few run past the text cap.
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
                if ($urandom_range(0, 4) == 0)
                    lim = $urandom_range(0, 63);
                else if (n >= MAXTXT)
                    lim = MAXTXT;
                else
                    lim = $urandom_range(n, MAXTXT);
                for (int i = 0; i < n; i++)
                    send_item(OP_TEXT, 8'($urandom), (i == n - 1), 16'($urandom), 6'(lim));
                sent += n;
            end
            else if (pick < 90)
            begin
                send_item(OP_TICK, 8'($urandom), 1'($urandom), 16'($urandom), 6'($urandom));
                sent++;
            end
            else
            begin
                send_item(OP_TEXT, 8'($urandom), 1'($urandom), 16'($urandom), 6'($urandom));
                sent++;
            end
        end
        // Flush any open text, then tick until the ring is empty.
        if (txt_count != 0)
            send_item(OP_TEXT, 8'($urandom), 1'b1, 16'($urandom), 6'($urandom));
        while (rd_slot != wr_slot)
            send_item(OP_TICK, 8'($urandom), 1'($urandom), 16'($urandom), 6'($urandom));
    endtask

    // Reset, directed tests, random traffic, then the final verdict.
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = OP_TEXT;
        text_byte      = 8'h00;
        text_last      = 1'b0;
        widget_address = 16'h0000;
        text_limit     = 6'd0;
        rd_slot        = 0;
        wr_slot        = 0;
        txt_count      = 0;
        latched_addr   = 16'h0000;
        in_idle_on     = 1'b1;
        out_idle_on    = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tick_on_empty_queue();
        test_field_extremes();
        test_text_past_limit();
        test_queue_full();
        test_random_traffic();

        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/mwfq_pkg.sv
rtl/modbus_write_frame_queue_top.sv
tb/modbus_write_frame_queue_top_tb.sv
